// File: rtl/core/turtle_vector_engine_assert.svh
// ----------------------------------------------------------------------------
// turtle_vector_engine_assert.svh
// Assertion macros shared by the turtle vector engine RTL.
// ----------------------------------------------------------------------------
`ifndef TURTLE_VECTOR_ENGINE_ASSERT_SVH
`define TURTLE_VECTOR_ENGINE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TVE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TVE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/tve_pkg.sv
// ----------------------------------------------------------------------------
// tve_pkg
// Types, constants and helper functions of the turtle vector engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tve_pkg;

  // Command codes
  localparam logic [2:0] CMD_MOVE_DIST = 3'd0;
  localparam logic [2:0] CMD_MOVE_XY   = 3'd1;
  localparam logic [2:0] CMD_MOVE_XYZ  = 3'd2;
  localparam logic [2:0] CMD_TURN      = 3'd3;
  localparam logic [2:0] CMD_TURN_TO   = 3'd4;
  localparam logic [2:0] CMD_PEN       = 3'd5;

  // Heading in 1/128 degree
  localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;

  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] LAST_RESET   = 32'sd655360000;
  localparam logic signed [12:0] PEN_INVISIBLE = -13'sd1;
  localparam logic signed [65:0] ROUND_HALF   = 66'sd536870912;

  localparam int STEP_W = 5;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              rot;
    logic              mul;
    logic              sum;
    logic              commit;
    logic [STEP_W-1:0] step;
  } tve_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_is_dist;
  } tve_stat_t;

  // Arctangent of 2^-i in units of 2^-23 degree
  function automatic logic signed [31:0] atan_at(input logic [STEP_W-1:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:  a = 32'sd377487360;
      5'd1:  a = 32'sd222843801;
      5'd2:  a = 32'sd117744544;
      5'd3:  a = 32'sd59768969;
      5'd4:  a = 32'sd30000467;
      5'd5:  a = 32'sd15014858;
      5'd6:  a = 32'sd7509261;
      5'd7:  a = 32'sd3754860;
      5'd8:  a = 32'sd1877459;
      5'd9:  a = 32'sd938733;
      5'd10: a = 32'sd469367;
      5'd11: a = 32'sd234683;
      5'd12: a = 32'sd117342;
      5'd13: a = 32'sd58671;
      5'd14: a = 32'sd29335;
      5'd15: a = 32'sd14668;
      5'd16: a = 32'sd7334;
      5'd17: a = 32'sd3667;
      5'd18: a = 32'sd1833;
      5'd19: a = 32'sd917;
      5'd20: a = 32'sd458;
      5'd21: a = 32'sd229;
      5'd22: a = 32'sd115;
      5'd23: a = 32'sd57;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  // Clamp a grown sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tve_datapath.sv
// ----------------------------------------------------------------------------
// tve_datapath
// Turtle state, CORDIC rotator, scaling multipliers and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tve_datapath import tve_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tve_cmd_t           ctrl,
  output tve_stat_t               stat,
  input  wire logic        [2:0]  in_cmd,
  input  wire logic signed [31:0] in_arg_x,
  input  wire logic signed [31:0] in_arg_y,
  input  wire logic signed [31:0] in_arg_z,
  input  wire logic signed [16:0] in_angle,
  input  wire logic signed [12:0] in_color,
  output logic                    out_draw_valid,
  output logic                    out_jump_first,
  output logic signed [31:0]      out_start_x,
  output logic signed [31:0]      out_start_y,
  output logic signed [31:0]      out_start_z,
  output logic signed [31:0]      out_end_x,
  output logic signed [31:0]      out_end_y,
  output logic signed [31:0]      out_end_z,
  output logic signed [31:0]      out_turtle_u,
  output logic signed [31:0]      out_turtle_v,
  output logic signed [16:0]      out_heading_now,
  output logic signed [12:0]      out_pen_now
);

  // Latched command
  logic        [2:0]  cmd_r;
  logic signed [31:0] ax_r, ay_r, az_r;
  logic signed [16:0] ang_r;
  logic signed [12:0] col_r;

  // Turtle state
  logic signed [31:0] u_r, v_r, sx_r, sy_r, sz_r;
  logic signed [16:0] hd_r;
  logic signed [12:0] pen_r;
  logic signed [31:0] lex_r, ley_r, lez_r;

  // CORDIC and scaling
  logic signed [33:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic               neg_r;
  logic signed [65:0] pc_r, ps_r;
  logic signed [31:0] nu_r, nv_r;

  // Result register
  logic               o_draw_r, o_jump_r;
  logic signed [31:0] o_sx_r, o_sy_r, o_sz_r, o_ex_r, o_ey_r, o_ez_r;
  logic signed [31:0] o_u_r, o_v_r;
  logic signed [16:0] o_hd_r;
  logic signed [12:0] o_pen_r;

  assign stat.load_is_dist = (in_cmd == CMD_MOVE_DIST);

  // Fold the heading into the right half plane for the rotator
  logic signed [17:0] hf;
  logic               fneg;
  always_comb begin
    hf   = 18'(hd_r);
    fneg = 1'b0;
    if (hf >= HALF_TURN) hf = hf - FULL_TURN;
    if (hf < -HALF_TURN) hf = hf + FULL_TURN;
    if (hf > QUARTER_TURN) begin
      hf   = hf - HALF_TURN;
      fneg = 1'b1;
    end else if (hf < -QUARTER_TURN) begin
      hf   = hf + HALF_TURN;
      fneg = 1'b1;
    end
  end

  // One rotation step
  logic signed [33:0] xs, ys;
  logic signed [31:0] at;
  always_comb begin
    xs = cx_r >>> ctrl.step;
    ys = cy_r >>> ctrl.step;
    at = atan_at(ctrl.step);
  end

  // Unfold cosine and sine
  logic signed [33:0] cos_v, sin_v;
  assign cos_v = neg_r ? -cx_r : cx_r;
  assign sin_v = neg_r ? -cy_r : cy_r;

  // Round the products and add to the position
  logic signed [65:0] rc, rs;
  assign rc = (pc_r + ROUND_HALF) >>> 30;
  assign rs = (ps_r + ROUND_HALF) >>> 30;

  // Commit: targets, segment and heading wrap
  logic signed [31:0] tx, ty;
  logic               pen_vis, is_move, drw, jmp;
  logic signed [31:0] ssx, ssy, ssz, sex, sey, sez;
  logic signed [17:0] hs;
  always_comb begin
    tx      = (cmd_r == CMD_MOVE_DIST) ? nu_r : ax_r;
    ty      = (cmd_r == CMD_MOVE_DIST) ? nv_r : ay_r;
    pen_vis = (pen_r != PEN_INVISIBLE);
    is_move = (cmd_r == CMD_MOVE_DIST) || (cmd_r == CMD_MOVE_XY) ||
              (cmd_r == CMD_MOVE_XYZ);
    drw     = is_move && pen_vis;
    if (cmd_r == CMD_MOVE_XYZ) begin
      ssx = sx_r; ssy = sy_r; ssz = sz_r;
      sex = ax_r; sey = ay_r; sez = az_r;
    end else begin
      ssx = u_r;  ssy = v_r;  ssz = 32'sd0;
      sex = tx;   sey = ty;   sez = 32'sd0;
    end
    jmp = (ssx != lex_r) || (ssy != ley_r) || (ssz != lez_r);
    // Truncated remainder keeps the sign of the sum
    hs = (cmd_r == CMD_TURN) ? 18'(hd_r) + 18'(ang_r) : 18'(ang_r);
    if (!hs[17]) begin
      if (hs >= FULL_TURN) hs = hs - FULL_TURN;
      if (hs >= FULL_TURN) hs = hs - FULL_TURN;
    end else begin
      if (hs <= -FULL_TURN) hs = hs + FULL_TURN;
      if (hs <= -FULL_TURN) hs = hs + FULL_TURN;
    end
  end

  // Turtle state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r   <= '0;
      v_r   <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sz_r  <= '0;
      hd_r  <= '0;
      pen_r <= PEN_INVISIBLE;
      lex_r <= LAST_RESET;
      ley_r <= LAST_RESET;
      lez_r <= LAST_RESET;
    end else if (ctrl.commit) begin
      case (cmd_r)
        CMD_MOVE_DIST, CMD_MOVE_XY: begin
          u_r <= tx;
          v_r <= ty;
        end
        CMD_MOVE_XYZ: begin
          sx_r <= ax_r;
          sy_r <= ay_r;
          sz_r <= az_r;
        end
        CMD_TURN, CMD_TURN_TO: begin
          hd_r <= 17'(hs);
        end
        CMD_PEN: begin
          pen_r <= col_r;
        end
        default: begin
        end
      endcase
      if (drw) begin
        lex_r <= sex;
        ley_r <= sey;
        lez_r <= sez;
      end
    end
  end

  // Capture the command, rotate, multiply, sum
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_cmd;
      ax_r  <= in_arg_x;
      ay_r  <= in_arg_y;
      az_r  <= in_arg_z;
      ang_r <= in_angle;
      col_r <= in_color;
      cx_r  <= INV_GAIN_Q30;
      cy_r  <= '0;
      cz_r  <= 32'(hf) <<< 16;
      neg_r <= fneg;
    end
    if (ctrl.rot) begin
      if (!cz_r[31]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end
    end
    if (ctrl.mul) begin
      pc_r <= 66'(ax_r) * 66'(cos_v);
      ps_r <= 66'(ax_r) * 66'(sin_v);
    end
    if (ctrl.sum) begin
      nu_r <= sat32(38'(u_r) + 38'(rc));
      nv_r <= sat32(38'(v_r) + 38'(rs));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      o_draw_r <= drw;
      o_jump_r <= drw && jmp;
      o_sx_r   <= drw ? ssx : 32'sd0;
      o_sy_r   <= drw ? ssy : 32'sd0;
      o_sz_r   <= drw ? ssz : 32'sd0;
      o_ex_r   <= drw ? sex : 32'sd0;
      o_ey_r   <= drw ? sey : 32'sd0;
      o_ez_r   <= drw ? sez : 32'sd0;
      o_u_r    <= ((cmd_r == CMD_MOVE_DIST) || (cmd_r == CMD_MOVE_XY)) ? tx : u_r;
      o_v_r    <= ((cmd_r == CMD_MOVE_DIST) || (cmd_r == CMD_MOVE_XY)) ? ty : v_r;
      o_hd_r   <= ((cmd_r == CMD_TURN) || (cmd_r == CMD_TURN_TO)) ? 17'(hs) : hd_r;
      o_pen_r  <= (cmd_r == CMD_PEN) ? col_r : pen_r;
    end
  end

  assign out_draw_valid  = o_draw_r;
  assign out_jump_first  = o_jump_r;
  assign out_start_x     = o_sx_r;
  assign out_start_y     = o_sy_r;
  assign out_start_z     = o_sz_r;
  assign out_end_x       = o_ex_r;
  assign out_end_y       = o_ey_r;
  assign out_end_z       = o_ez_r;
  assign out_turtle_u    = o_u_r;
  assign out_turtle_v    = o_v_r;
  assign out_heading_now = o_hd_r;
  assign out_pen_now     = o_pen_r;

endmodule

`default_nettype wire

// File: rtl/core/tve_ctrl.sv
// ----------------------------------------------------------------------------
// tve_ctrl
// Command sequencer: accept, rotate, multiply, sum, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "turtle_vector_engine_assert.svh"

module tve_ctrl import tve_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire tve_stat_t stat,
  output tve_cmd_t       ctrl
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free, accept, last_step;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign last_step = (cnt_r == CNT_W'(CORDIC_STEPS - 1));

  // Next state and step count
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = stat.load_is_dist ? S_ROT : S_FIN;
          cnt_nxt   = '0;
        end
      end
      S_ROT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_SUM;
      S_SUM: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctrl.load   = accept;
    ctrl.rot    = (state_r == S_ROT);
    ctrl.mul    = (state_r == S_MUL);
    ctrl.sum    = (state_r == S_SUM);
    ctrl.commit = (state_r == S_FIN) && out_free;
    ctrl.step   = STEP_W'(cnt_r);
  end

  // Hold the result until its transfer
  assign out_valid_nxt = ctrl.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TVE_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE, "idle after accept")
  `TVE_ASSERT_NEXT(a_rot_to_mul, clk, rst_n, (state_r == S_ROT) && last_step, state_r == S_MUL, "rotator overrun")
  `TVE_ASSERT_SAME(a_commit_free, clk, rst_n, ctrl.commit, !out_valid_r || !out_stall, "result overwritten")
  `TVE_ASSERT_NEXT(a_fin_hold, clk, rst_n, (state_r == S_FIN) && out_valid_r && out_stall, state_r == S_FIN, "left commit early")

endmodule

`default_nettype wire

// File: rtl/core/turtle_vector_engine.sv
// ----------------------------------------------------------------------------
// turtle_vector_engine
// Turtle graphics command engine with CORDIC move-by-distance.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | cmd, arg_x/y/z, angle, color
//  out     | output    | out_valid/out_stall | segment, position, heading, pen
//
// Move by distance runs CORDIC_STEPS rotation steps on the shared rotator, one
// step per cycle, then multiplies, sums and commits; other commands go to commit.
// The result register frees the input: a new command is taken while a result
// waits. Reset is synchronous; state returns to origin, heading 0, pen off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module turtle_vector_engine import tve_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  in_cmd,
  input  wire logic signed [31:0] in_arg_x,
  input  wire logic signed [31:0] in_arg_y,
  input  wire logic signed [31:0] in_arg_z,
  input  wire logic signed [16:0] in_angle,
  input  wire logic signed [12:0] in_color,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_draw_valid,
  output logic                    out_jump_first,
  output logic signed [31:0]      out_start_x,
  output logic signed [31:0]      out_start_y,
  output logic signed [31:0]      out_start_z,
  output logic signed [31:0]      out_end_x,
  output logic signed [31:0]      out_end_y,
  output logic signed [31:0]      out_end_z,
  output logic signed [31:0]      out_turtle_u,
  output logic signed [31:0]      out_turtle_v,
  output logic signed [16:0]      out_heading_now,
  output logic signed [12:0]      out_pen_now
);

  tve_cmd_t  ctrl;
  tve_stat_t stat;

  // Sequencer
  tve_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Datapath
  tve_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_arg_x        (in_arg_x),
    .in_arg_y        (in_arg_y),
    .in_arg_z        (in_arg_z),
    .in_angle        (in_angle),
    .in_color        (in_color),
    .out_draw_valid  (out_draw_valid),
    .out_jump_first  (out_jump_first),
    .out_start_x     (out_start_x),
    .out_start_y     (out_start_y),
    .out_start_z     (out_start_z),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_end_z       (out_end_z),
    .out_turtle_u    (out_turtle_u),
    .out_turtle_v    (out_turtle_v),
    .out_heading_now (out_heading_now),
    .out_pen_now     (out_pen_now)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for turtle_vector_engine: queued commands are driven
// through the valid/stall port, a local model of the turtle predicts every
// result, and a monitor compares each result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tve_pkg::*;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [16:0] ang;
    logic signed [12:0] col;
  } turtle_cmd_t;

  typedef struct packed {
    logic               draw;
    logic               jump;
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic signed [31:0] tu, tv;
    logic signed [16:0] hd;
    logic signed [12:0] pen;
  } turtle_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = '0;
  logic signed [31:0] in_arg_x = '0, in_arg_y = '0, in_arg_z = '0;
  logic signed [16:0] in_angle = '0;
  logic signed [12:0] in_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_draw_valid, out_jump_first;
  logic signed [31:0] out_start_x, out_start_y, out_start_z;
  logic signed [31:0] out_end_x, out_end_y, out_end_z;
  logic signed [31:0] out_turtle_u, out_turtle_v;
  logic signed [16:0] out_heading_now;
  logic signed [12:0] out_pen_now;

  turtle_vector_engine i_dut (.*);

  // Turtle state mirrored by the bench
  logic signed [31:0] pos_u, pos_v, sp_x, sp_y, sp_z;
  logic signed [31:0] heading, pen;
  logic signed [31:0] last_pt [3];

  turtle_cmd_t cmd_queue[$];
  turtle_res_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 1'b0;
  bit stim_done = 1'b0;

  // Free-running clock, 8 ns period
  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint atan_ref(int i);
    longint t[24] = '{377487360, 222843801, 117744544, 59768969, 30000467,
      15014858, 7509261, 3754860, 1877459, 938733, 469367, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};
    return t[i];
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // Rotate the unit vector to heading h; returns cos and sin in Q30
  task automatic rotate_heading(input int hin, output longint c, output longint s);
    longint x, y, z, t;
    int h;
    bit neg;
    h = hin;
    x = 652032874;
    y = 0;
    neg = 0;
    if (h >= 23040) h -= 46080;
    if (h < -23040) h += 46080;
    if (h > 11520) begin
      h -= 23040;
      neg = 1;
    end else if (h < -11520) begin
      h += 23040;
      neg = 1;
    end
    z = longint'(h) * 65536;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= atan_ref(i);
      end else begin
        t = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += atan_ref(i);
      end
      x = t;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic segment(inout turtle_res_t r, input logic signed [31:0] sx, sy, sz,
                         ex, ey, ez);
    if (pen != -1) begin
      r.draw = 1;
      r.jump = (sx != last_pt[0]) || (sy != last_pt[1]) || (sz != last_pt[2]);
      r.sx = sx; r.sy = sy; r.sz = sz;
      r.ex = ex; r.ey = ey; r.ez = ez;
      last_pt[0] = ex; last_pt[1] = ey; last_pt[2] = ez;
    end
  endtask

  // Advance the mirrored turtle by one command and queue its result
  task automatic predict_turtle(input turtle_cmd_t c);
    turtle_res_t r;
    longint cs, sn;
    logic signed [31:0] nu, nv;
    r = '0;
    case (c.cmd)
      CMD_MOVE_DIST: begin
        rotate_heading(heading, cs, sn);
        nu = clamp32(longint'(pos_u) + shr_floor(longint'(c.ax) * cs + (64'sd1 << 29), 30));
        nv = clamp32(longint'(pos_v) + shr_floor(longint'(c.ax) * sn + (64'sd1 << 29), 30));
        segment(r, pos_u, pos_v, 0, nu, nv, 0);
        pos_u = nu; pos_v = nv;
      end
      CMD_MOVE_XY: begin
        segment(r, pos_u, pos_v, 0, c.ax, c.ay, 0);
        pos_u = c.ax; pos_v = c.ay;
      end
      CMD_MOVE_XYZ: begin
        segment(r, sp_x, sp_y, sp_z, c.ax, c.ay, c.az);
        sp_x = c.ax; sp_y = c.ay; sp_z = c.az;
      end
      CMD_TURN: heading = (heading + int'(c.ang)) % 46080;
      CMD_TURN_TO: heading = int'(c.ang) % 46080;
      CMD_PEN: pen = int'(c.col);
      default: ;
    endcase
    r.tu = pos_u; r.tv = pos_v;
    r.hd = 17'(heading); r.pen = 13'(pen);
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return 32'($urandom_range(0, 4000)) - 2000;
      3: return 32'sd655360000;
      default: return $urandom;
    endcase
  endfunction

  function automatic turtle_cmd_t rnd_cmd();
    turtle_cmd_t c;
    c.cmd = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
    c.ax = rnd_coord();
    c.ay = rnd_coord();
    c.az = rnd_coord();
    c.ang = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                        : 17'(int'($urandom_range(0, 92158)) - 46079);
    case ($urandom_range(0, 5))
      0: c.col = -13'sd1;
      1: c.col = 13'($urandom);
      default: c.col = 13'($urandom_range(0, 4095));
    endcase
    if (c.cmd == CMD_MOVE_DIST && $urandom_range(0, 1)) c.ax = 32'($urandom_range(0, 1 << 22));
    return c;
  endfunction

  task automatic add_cmd(input logic [2:0] k, input logic signed [31:0] x, y, z,
                         input logic signed [16:0] a, input logic signed [12:0] col);
    turtle_cmd_t c;
    c.cmd = k; c.ax = x; c.ay = y; c.az = z; c.ang = a; c.col = col;
    cmd_queue.push_back(c);
  endtask

  // Driver: present queued commands, hold while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) begin
      end else if (cmd_queue.size() != 0 && !hold_send &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        turtle_cmd_t c;
        c = cmd_queue.pop_front();
        predict_turtle(c);
        in_valid <= 1'b1;
        in_cmd <= c.cmd; in_arg_x <= c.ax; in_arg_y <= c.ay; in_arg_z <= c.az;
        in_angle <= c.ang; in_color <= c.col;
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        turtle_res_t e;
        e = expected_q.pop_front();
        if (out_draw_valid !== e.draw) report_mismatch("draw_valid", out_draw_valid, e.draw);
        if (out_jump_first !== e.jump) report_mismatch("jump_first", out_jump_first, e.jump);
        if (out_start_x !== e.sx) report_mismatch("start_x", out_start_x, e.sx);
        if (out_start_y !== e.sy) report_mismatch("start_y", out_start_y, e.sy);
        if (out_start_z !== e.sz) report_mismatch("start_z", out_start_z, e.sz);
        if (out_end_x !== e.ex) report_mismatch("end_x", out_end_x, e.ex);
        if (out_end_y !== e.ey) report_mismatch("end_y", out_end_y, e.ey);
        if (out_end_z !== e.ez) report_mismatch("end_z", out_end_z, e.ez);
        if (out_turtle_u !== e.tu) report_mismatch("turtle_u", out_turtle_u, e.tu);
        if (out_turtle_v !== e.tv) report_mismatch("turtle_v", out_turtle_v, e.tv);
        if (out_heading_now !== e.hd) report_mismatch("heading_now", out_heading_now, e.hd);
        if (out_pen_now !== e.pen) report_mismatch("pen_now", out_pen_now, e.pen);
      end
    end
  end

  // Stimulus and phases
  initial begin
    pos_u = 0; pos_v = 0; sp_x = 0; sp_y = 0; sp_z = 0;
    heading = 0; pen = -1;
    last_pt[0] = 655360000; last_pt[1] = 655360000; last_pt[2] = 655360000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: invisible moves, extremes, wraps, jump cases
    add_cmd(CMD_MOVE_DIST, 32'sh10000, 0, 0, 0, 0);
    add_cmd(CMD_MOVE_XYZ, 1, 2, 3, 0, 0);
    add_cmd(CMD_PEN, 0, 0, 0, 0, 13'sd4095);
    add_cmd(CMD_MOVE_XY, 32'sd655360000, 32'sd655360000, 0, 0, 0);
    add_cmd(CMD_MOVE_XY, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0);
    add_cmd(CMD_MOVE_XYZ, 32'sd655360000, 32'sd655360000, 32'sd655360000, 0, 0);
    add_cmd(CMD_MOVE_XYZ, 5, 6, 7, 0, 0);
    add_cmd(CMD_MOVE_DIST, 32'sh7FFFFFFF, 0, 0, 0, 0);
    add_cmd(CMD_TURN_TO, 0, 0, 0, 17'sd23040, 0);
    add_cmd(CMD_MOVE_DIST, 32'sh7FFFFFFF, 0, 0, 0, 0);
    add_cmd(CMD_MOVE_DIST, 32'sh80000000, 0, 0, 0, 0);
    add_cmd(CMD_TURN, 0, 0, 0, 17'sd46079, 0);
    add_cmd(CMD_TURN, 0, 0, 0, 17'sd46079, 0);
    add_cmd(CMD_TURN, 0, 0, 0, -17'sd46079, 0);
    add_cmd(CMD_TURN_TO, 0, 0, 0, -17'sd65536, 0);
    add_cmd(CMD_MOVE_DIST, 32'sh00640000, 0, 0, 0, 0);
    add_cmd(CMD_TURN_TO, 0, 0, 0, 17'sd11520, 0);
    add_cmd(CMD_MOVE_DIST, -32'sh00640000, 0, 0, 0, 0);
    add_cmd(CMD_PEN, 0, 0, 0, 0, -13'sd4096);
    add_cmd(CMD_MOVE_XY, 3, 4, 0, 0, 0);
    add_cmd(3'd6, 1, 1, 1, 17'sd100, 13'sd5);
    add_cmd(3'd7, 1, 1, 1, 17'sd100, 13'sd5);
    add_cmd(CMD_PEN, 0, 0, 0, 0, -13'sd1);
    add_cmd(CMD_MOVE_XY, 9, 9, 0, 0, 0);
    add_cmd(CMD_PEN, 0, 0, 0, 0, 13'sd1);
    wait (cmd_queue.size() == 0 && expected_q.size() == 0);

    // Random phases with varying input idle and output stall pressure
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 48 : 31) : 0;
      recv_stall_pct = (ph == 2) ? 48 : ((ph == 3) ? 31 : 0);
      for (int n = 0; n < 300; n++) begin
        if (n % 6 == 0 && $urandom_range(0, 1))
          add_cmd(CMD_PEN, 0, 0, 0, 0, 13'($urandom_range(0, 4095)));
        cmd_queue.push_back(rnd_cmd());
      end
      wait (cmd_queue.size() == 0);
      // Pause input until the engine drains
      hold_send = 1'b1;
      wait (expected_q.size() == 0);
      hold_send = 1'b0;
    end
    recv_stall_pct = 0;
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("turtle_vector_engine regression: pass");
    end else begin
      $display("turtle_vector_engine regression: fail");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(8 * 400000);
    $display("turtle_vector_engine regression: fail");
    $finish;
  end

endmodule
